FILE: rtl/separable_gaussian_blur_rgb_macros.svh
// Assertion macros shared by the blur checker.
// No dependencies; include by bare file name.
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_MACROS_SVH
// same-cycle implication, off during reset
`define SGB_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("sgb check failed");
// next-cycle implication, off during reset
`define SGB_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("sgb check failed");
// next-cycle implication, live through reset
`define SGB_ASSERT_RST(lbl, a, c) lbl: assert property (@(posedge clk) \
  (a) |=> (c)) else $error("sgb check failed");
`endif

FILE: rtl/sgb_pkg.sv
// Types, register codes and arithmetic helpers for the separable blur.
// No dependencies.
package sgb_pkg;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 13;
  localparam int POS_W  = 26;
  localparam int PIX_W  = 24;
  localparam int SLOT_W = 5;
  localparam int ACC_W  = 28;
  localparam int COEF_W = 16;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 64;

  localparam logic [CIDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_HALF    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_COEF_LO = 3'd3;
  localparam logic [CIDX_W-1:0] REG_COEF_HI = 3'd4;

  typedef struct packed {
    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] ht;
    logic [3:0]       h;
  } geom_t;

  typedef struct packed {
    logic              is_pix;
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              emit;
    logic [COL_W-1:0]  ox;
    logic [ROW_W-1:0]  oy;
    logic [SLOT_W-1:0] oslot;
    logic              last;
  } task_t;

  function automatic logic [COEF_W-1:0] coef_at(input logic [CDAT_W-1:0] lo,
                                                input logic [CDAT_W-1:0] hi,
                                                input logic [3:0] d);
    logic [COEF_W-1:0] c;
    unique case (d[3:2])
      2'd0:    c = lo[16*d[1:0] +: COEF_W];
      2'd1:    c = hi[16*d[1:0] +: COEF_W];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(16384);
    return (s[ACC_W:15] > (ACC_W-14)'(255)) ? 8'hFF : s[22:15];
  endfunction
endpackage

FILE: rtl/separable_gaussian_blur_rgb.sv
// Separable blur of a BGR pixel stream. Input pixels are taken one per cycle
// while in_tready is high, into a four-deep task queue; the back end runs the
// vertical pass of a pixel with a result, each horizontal column, and at a row
// end up to half_taps+1 columns, all on one shared tap multiplier set stepping
// one tap per cycle. Results trail inputs by half_taps rows plus half_taps
// pixels; flush beats drain the tail. A geometry write restarts the frame, and
// any config write holds in_tready low for one cycle.
module separable_gaussian_blur_rgb #(
  parameter int MAX_HALF_TAPS = 7,
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_blue, in_green, in_red
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_blue, out_green, out_red
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  half_r;
  logic [63:0] coef_lo_r, coef_hi_r;
  logic cfg_wr, geo_wr, q_full, q_empty, q_push, q_pop;
  sgb_pkg::geom_t geom;
  sgb_pkg::task_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign geo_wr    = cfg_wr && (cfg_index == sgb_pkg::REG_WIDTH ||
                                cfg_index == sgb_pkg::REG_HEIGHT ||
                                cfg_index == sgb_pkg::REG_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 12'd900;
      height_r  <= 13'd450;
      half_r    <= 3'd5;
      coef_lo_r <= '0;
      coef_hi_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        sgb_pkg::REG_WIDTH:   width_r   <= cfg_data[11:0];
        sgb_pkg::REG_HEIGHT:  height_r  <= cfg_data[12:0];
        sgb_pkg::REG_HALF:    half_r    <= cfg_data[2:0];
        sgb_pkg::REG_COEF_LO: coef_lo_r <= cfg_data;
        sgb_pkg::REG_COEF_HI: coef_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    geom.w  = (width_r == '0) ? 12'd1 :
              (32'(width_r) > MAX_WIDTH) ? 12'(MAX_WIDTH) : width_r;
    geom.ht = (height_r == '0) ? 13'd1 :
              (32'(height_r) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_r;
    geom.h  = (32'(half_r) > MAX_HALF_TAPS) ? 4'(MAX_HALF_TAPS) : {1'b0, half_r};
  end

  sgb_front #(.MAX_HALF_TAPS(MAX_HALF_TAPS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .geom, .geo_wr, .cfg_wr, .q_full, .q_push, .q_data(q_wdata)
  );

  sgb_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  sgb_back #(.MAX_HALF_TAPS(MAX_HALF_TAPS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk, .rst_n, .geom, .coef_lo(coef_lo_r), .coef_hi(coef_hi_r),
    .q_empty, .q_data(q_rdata), .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule

FILE: rtl/sgb_front.sv
// Front end: accepts input beats, tracks frame positions, emits work tasks.
// Depends on sgb_pkg.
module sgb_front #(
  parameter int MAX_HALF_TAPS = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,
  input  logic                 in_tuser,
  input  sgb_pkg::geom_t       geom,
  input  logic                 geo_wr,
  input  logic                 cfg_wr,
  input  logic                 q_full,
  output logic                 q_push,
  output sgb_pkg::task_t       q_data
);
  localparam int D = 2 * MAX_HALF_TAPS + 1;
  localparam logic [sgb_pkg::SLOT_W-1:0] SLOT_LAST = sgb_pkg::SLOT_W'(D - 1);

  logic [sgb_pkg::POS_W-1:0]  total_r, lag_r, in_pos_r, in_pos_nxt;
  logic [sgb_pkg::COL_W-1:0]  col_r, col_nxt, ox_r, ox_nxt;
  logic [sgb_pkg::SLOT_W-1:0] slot_r, slot_nxt, oslot_r, oslot_nxt;
  logic [sgb_pkg::ROW_W-1:0]  oy_r, oy_nxt;
  logic settle_r;
  logic take, take_pix, adv, emit, last, col_end;

  assign in_tready = !q_full && !settle_r;
  assign take      = in_tvalid && in_tready;
  assign take_pix  = !in_tuser && (in_pos_r < total_r);
  assign adv       = take_pix || (in_pos_r >= total_r);
  assign emit      = adv && (in_pos_r >= lag_r);
  assign last      = emit && (oy_r == geom.ht - 1'b1) && (ox_r == geom.w - 1'b1);
  assign col_end   = (col_r == geom.w - 1'b1);
  assign q_push    = take && (take_pix || emit);

  always_comb begin
    q_data.is_pix = take_pix;
    q_data.pix    = in_tdata;
    q_data.col    = col_r;
    q_data.slot   = slot_r;
    q_data.emit   = emit;
    q_data.ox     = ox_r;
    q_data.oy     = oy_r;
    q_data.oslot  = oslot_r;
    q_data.last   = last;
  end

  always_comb begin
    in_pos_nxt = in_pos_r;
    col_nxt    = col_r;
    slot_nxt   = slot_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oslot_nxt  = oslot_r;
    if (geo_wr) begin
      in_pos_nxt = '0;
      col_nxt    = '0;
      slot_nxt   = '0;
      ox_nxt     = '0;
      oy_nxt     = '0;
      oslot_nxt  = '0;
    end else if (take && adv) begin
      in_pos_nxt = in_pos_r + 1'b1;
      if (take_pix) begin
        if (col_end) begin
          col_nxt  = '0;
          slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      if (emit) begin
        if (ox_r == geom.w - 1'b1) begin
          ox_nxt    = '0;
          oy_nxt    = oy_r + 1'b1;
          oslot_nxt = (oslot_r == SLOT_LAST) ? '0 : oslot_r + 1'b1;
        end else begin
          ox_nxt = ox_r + 1'b1;
        end
      end
      if (last) begin
        in_pos_nxt = '0;
        col_nxt    = '0;
        slot_nxt   = '0;
        ox_nxt     = '0;
        oy_nxt     = '0;
        oslot_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= sgb_pkg::POS_W'(geom.w) * sgb_pkg::POS_W'(geom.ht);
    lag_r   <= sgb_pkg::POS_W'(geom.h) * sgb_pkg::POS_W'(geom.w) + sgb_pkg::POS_W'(geom.h);
    if (!rst_n) begin
      settle_r <= 1'b0;
      in_pos_r <= '0;
      col_r    <= '0;
      slot_r   <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      oslot_r  <= '0;
    end else begin
      // hold off input so frame size and lag catch up with a write
      settle_r <= cfg_wr;
      in_pos_r <= in_pos_nxt;
      col_r    <= col_nxt;
      slot_r   <= slot_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      oslot_r  <= oslot_nxt;
    end
  end
endmodule

FILE: rtl/sgb_queue.sv
// Four-entry task queue between front and back end.
// Depends on sgb_pkg.
module sgb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sgb_pkg::task_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sgb_pkg::task_t rdata
);
  localparam int DEPTH = 4;

  sgb_pkg::task_t mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'(DEPTH));
  assign empty = (cnt_r == 3'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
endmodule

FILE: rtl/sgb_back.sv
// Back end: row window, horizontal and vertical tap sequencer, row store,
// output register. Depends on sgb_pkg.
module sgb_back #(
  parameter int MAX_HALF_TAPS = 7,
  parameter int MAX_WIDTH     = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgb_pkg::geom_t              geom,
  input  logic [sgb_pkg::CDAT_W-1:0]  coef_lo,
  input  logic [sgb_pkg::CDAT_W-1:0]  coef_hi,
  input  logic                        q_empty,
  input  sgb_pkg::task_t              q_data,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,
  output logic                        out_tlast
);
  localparam int D  = 2 * MAX_HALF_TAPS + 1;
  localparam int SW = $clog2(D);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int AW = SW + XW;
  localparam int ACC_W = sgb_pkg::ACC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HMAC = 3'd1;
  localparam logic [2:0] ST_HWR  = 3'd2;
  localparam logic [2:0] ST_VRD  = 3'd3;
  localparam logic [2:0] ST_VDRN = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  sgb_pkg::task_t cur_r, cur_nxt;
  logic [sgb_pkg::COL_W-1:0] x_r, x_nxt, xe_r, xe_nxt;
  logic signed [4:0] k_r, k_nxt;
  logic [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0] acc_nxt [3];
  logic [sgb_pkg::PIX_W-1:0] win_r [D];
  logic [sgb_pkg::PIX_W-1:0] mem [2**AW];
  logic [sgb_pkg::PIX_W-1:0] rdata_r;
  logic rd_pend_r, rd_pend_nxt;
  logic [sgb_pkg::COEF_W-1:0] rd_coef_r, rd_coef_nxt;
  logic out_valid_r, out_last_r;
  logic [23:0] out_data_r;

  logic signed [4:0] hs;
  logic [3:0] kabs;
  logic [sgb_pkg::COEF_W-1:0] coef;
  logic signed [14:0] j, sl, yy;
  logic signed [6:0] vs;
  logic [sgb_pkg::SLOT_W-1:0] vslot;
  logic h_ok, v_ok, shift_en, out_load, mem_we;
  logic [sgb_pkg::PIX_W-1:0] tap_pix;
  logic [AW-1:0] waddr, raddr;
  logic [23:0] res;
  logic c_ge_h, row_end;

  assign hs   = $signed({1'b0, geom.h});
  assign kabs = (k_r < 0) ? 4'(-k_r) : 4'(k_r);
  assign coef = sgb_pkg::coef_at(coef_lo, coef_hi, kabs);

  // horizontal tap: column j of the current row sits at window slot c - j
  assign j    = $signed({3'b0, x_r}) + 15'(k_r);
  assign sl   = $signed({3'b0, cur_r.col}) - j;
  assign h_ok = (j >= 0) && (j < $signed({3'b0, geom.w})) && (sl >= 0) && (sl < 15'(D));
  assign tap_pix = h_ok ? win_r[sl[SW-1:0]] : '0;

  // vertical tap: row oy + k lives in ring slot oslot + k
  assign yy    = $signed({2'b0, cur_r.oy}) + 15'(k_r);
  assign v_ok  = (yy >= 0) && (yy < $signed({2'b0, geom.ht}));
  assign vs    = $signed({2'b0, cur_r.oslot}) + 7'(k_r);
  assign vslot = (vs < 0) ? sgb_pkg::SLOT_W'(vs + 7'(D)) :
                 (vs >= 7'(D)) ? sgb_pkg::SLOT_W'(vs - 7'(D)) : sgb_pkg::SLOT_W'(vs);
  assign raddr = {vslot[SW-1:0], XW'(cur_r.ox)};
  assign waddr = {cur_r.slot[SW-1:0], XW'(x_r)};

  assign res = {sgb_pkg::round_sat(acc_r[2]), sgb_pkg::round_sat(acc_r[1]),
                sgb_pkg::round_sat(acc_r[0])};

  assign c_ge_h  = (q_data.col >= sgb_pkg::COL_W'(geom.h));
  assign row_end = (q_data.col == geom.w - 1'b1);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    x_nxt       = x_r;
    xe_nxt      = xe_r;
    k_nxt       = k_r;
    acc_nxt     = acc_r;
    rd_pend_nxt = 1'b0;
    rd_coef_nxt = rd_coef_r;
    q_pop       = 1'b0;
    shift_en    = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    if (rd_pend_r) begin
      for (int i = 0; i < 3; i++) begin
        acc_nxt[i] = acc_r[i] + ACC_W'(rd_coef_r) * ACC_W'(rdata_r[8*i +: 8]);
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_nxt  = q_data;
          shift_en = q_data.is_pix;
          x_nxt    = c_ge_h ? q_data.col - sgb_pkg::COL_W'(geom.h) : '0;
          xe_nxt   = row_end ? q_data.col : q_data.col - sgb_pkg::COL_W'(geom.h);
          k_nxt    = -hs;
          for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
          if (q_data.is_pix && (c_ge_h || row_end)) state_nxt = ST_HMAC;
          else if (q_data.emit) state_nxt = ST_VRD;
        end
      end
      ST_HMAC: begin
        for (int i = 0; i < 3; i++) begin
          acc_nxt[i] = acc_r[i] + ACC_W'(coef) * ACC_W'(tap_pix[8*i +: 8]);
        end
        if (k_r == hs) state_nxt = ST_HWR;
        else k_nxt = k_r + 1'b1;
      end
      ST_HWR: begin
        mem_we = 1'b1;
        k_nxt  = -hs;
        for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
        if (x_r == xe_r) begin
          state_nxt = cur_r.emit ? ST_VRD : ST_IDLE;
        end else begin
          x_nxt     = x_r + 1'b1;
          state_nxt = ST_HMAC;
        end
      end
      ST_VRD: begin
        rd_pend_nxt = v_ok;
        rd_coef_nxt = coef;
        if (k_r == hs) state_nxt = ST_VDRN;
        else k_nxt = k_r + 1'b1;
      end
      ST_VDRN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= res;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    x_r       <= x_nxt;
    xe_r      <= xe_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    rd_coef_r <= rd_coef_nxt;
    if (out_load) begin
      out_data_r <= res;
      out_last_r <= cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < D; i++) win_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (shift_en) begin
        win_r[0] <= q_data.pix;
        for (int i = 1; i < D; i++) win_r[i] <= win_r[i-1];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule

FILE: rtl/sgb_checker.sv
// Port-level checks for the blur block, bound to the top level.
// Depends on separable_gaussian_blur_rgb_macros.svh.
`include "separable_gaussian_blur_rgb_macros.svh"
module sgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  `SGB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SGB_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  `SGB_ASSERT_NXT(a_cfg_settle, cfg_valid && cfg_ready, !in_tready)
  `SGB_ASSERT_RST(a_rst_idle, !rst_n, !out_tvalid)
endmodule

bind separable_gaussian_blur_rgb sgb_checker u_sgb_checker (.*);
